// ===== sv/mcr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants of the MIDI controller / RPN store.
// ---------------------------------------------------------------------------
package mcr_pkg;

  localparam int VOICES_DEF      = 32;
  localparam int SETS_DEF        = 8;
  localparam int CONTROLLERS_DEF = 134;

  localparam int CTRL_W = 8;
  localparam int SET_W  = 3;
  localparam int CH_W   = 4;
  localparam int VAL_W  = 16;
  localparam int SLOT_W = 5;
  localparam int BR_W   = 5;
  localparam int CV_W   = 7;
  localparam int ACT_W  = 6;
  localparam int SC_W   = SET_W + CH_W;
  localparam int CA_W   = SC_W + CTRL_W;
  localparam int EA_W   = CH_W + CTRL_W;

  localparam logic [CTRL_W-1:0] CC_DATA_MSB = 8'd6;
  localparam logic [CTRL_W-1:0] CC_DEC      = 8'd96;
  localparam logic [CTRL_W-1:0] CC_INC      = 8'd97;
  localparam logic [CTRL_W-1:0] CC_RPN_LSB  = 8'd100;
  localparam logic [CTRL_W-1:0] CC_RPN_MSB  = 8'd101;
  localparam logic [BR_W-1:0]   MAX_BEND    = 5'd24;
  localparam logic [ACT_W-1:0]  ACTIVE_RST  = 6'd32;

  typedef enum logic [1:0] {
    CMD_WR7  = 2'd0,
    CMD_WR14 = 2'd1,
    CMD_BIND = 2'd2,
    CMD_READ = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_BIND  = 2'd0,
    K_READ  = 2'd1,
    K_WRITE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    status_t           status;
    logic              fx;
    logic [SET_W-1:0]  set_idx;
    logic [CH_W-1:0]   ch;
    logic              two_ops;
    logic [CTRL_W-1:0] c0;
    logic [CV_W-1:0]   v0;
    logic [CTRL_W-1:0] c1;
    logic [CV_W-1:0]   v1;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic              bind_on;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] voice_index;
    logic              bend_range_set;
    logic [BR_W-1:0]   bend_range;
    logic [CV_W-1:0]   read_value;
    logic              dirty_mark;
    logic [1:0]        status;
    logic              last;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FETCH, S_LATCH, S_OP, S_RPN_L, S_RPN_M, S_RPN_EVAL,
    S_WRITE, S_SCAN, S_FINAL
  } state_t;

endpackage

// ===== sv/mcr_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcr_in_if / mcr_out_if
// Valid/ready channels for command items and result items.
// ---------------------------------------------------------------------------
interface mcr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  controller;
  logic [3:0]  channel;
  logic        channel_absent;
  logic [2:0]  set_index;
  logic        fx_set;
  logic [15:0] value;
  logic [4:0]  voice_slot;
  logic        bind_valid;

  modport source (output valid, command, controller, channel, channel_absent, set_index,
                  fx_set, value, voice_slot, bind_valid, input ready);
  modport sink (input valid, command, controller, channel, channel_absent, set_index,
                fx_set, value, voice_slot, bind_valid, output ready);
endinterface

interface mcr_out_if;
  logic       valid;
  logic       ready;
  logic       result_kind;
  logic [4:0] voice_index;
  logic       bend_range_set;
  logic [4:0] bend_range;
  logic [6:0] read_value;
  logic       dirty_mark;
  logic [1:0] status;
  logic       last;

  modport source (output valid, result_kind, voice_index, bend_range_set, bend_range,
                  read_value, dirty_mark, status, last, input ready);
  modport sink (input valid, result_kind, voice_index, bend_range_set, bend_range,
                read_value, dirty_mark, status, last, output ready);
endinterface

// ===== sv/mcr_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcr_front
// Accepts command items, checks them and splits 14-bit writes.
// ---------------------------------------------------------------------------
module mcr_front #(
  parameter int VOICES      = mcr_pkg::VOICES_DEF,
  parameter int SETS        = mcr_pkg::SETS_DEF,
  parameter int CONTROLLERS = mcr_pkg::CONTROLLERS_DEF
) (
  mcr_in_if.sink          in_ch,
  input  logic            busy,
  input  logic            push_ready,
  output logic            push_valid,
  output mcr_pkg::item_t  push_item
);
  import mcr_pkg::*;

  logic [CTRL_W-1:0] c;
  logic [CV_W-1:0]   hi;
  logic [CV_W-1:0]   lo;
  logic              bad;
  item_t             it;

  assign in_ch.ready = push_ready && !busy;
  assign push_valid  = in_ch.valid && !busy;
  assign push_item   = it;

  always_comb begin
    c   = in_ch.controller;
    hi  = in_ch.value[13:7];
    lo  = in_ch.value[6:0];
    bad = ({1'b0, c} >= 9'(CONTROLLERS)) ||
          (!in_ch.fx_set && ({2'b0, in_ch.set_index} >= 5'(SETS)));
    it         = '0;
    it.fx      = in_ch.fx_set;
    it.set_idx = in_ch.set_index;
    it.ch      = in_ch.channel;
    it.slot    = in_ch.voice_slot;
    it.slot_ok = {2'b0, in_ch.voice_slot} < 7'(VOICES);
    it.bind_on = in_ch.bind_valid;
    it.c0      = c;
    it.v0      = lo;
    it.status  = ST_OK;
    unique case (cmd_t'(in_ch.command))
      CMD_BIND: it.kind = K_BIND;
      CMD_READ: it.kind = K_READ;
      default:  it.kind = K_WRITE;
    endcase
    if (cmd_t'(in_ch.command) != CMD_BIND) begin
      if (in_ch.channel_absent) it.status = ST_ABSENT;
      else if (bad) it.status = ST_INVALID;
    end
    if (cmd_t'(in_ch.command) == CMD_WR14) begin
      if (c < 8'd64) begin
        it.c0      = {3'b0, c[4:0]};
        it.v0      = hi;
        it.c1      = {3'b001, c[4:0]};
        it.v1      = lo;
        it.two_ops = 1'b1;
      end else if (c == 8'd128 || c == 8'd129 || c == 8'd132 || c == 8'd133) begin
        it.c0      = {c[7:1], 1'b0};
        it.v0      = hi;
        it.c1      = {c[7:1], 1'b1};
        it.v1      = lo;
        it.two_ops = 1'b1;
      end else begin
        it.v0 = hi;
      end
    end
  end

endmodule

// ===== sv/mcr_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcr_fifo
// Two-entry queue of checked items between front and back.
// ---------------------------------------------------------------------------
module mcr_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  mcr_pkg::item_t  push_item,
  output logic            pop_valid,
  input  logic            pop,
  output mcr_pkg::item_t  pop_item
);
  import mcr_pkg::*;

  item_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_item;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== sv/mcr_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mcr_back
// Executes items: controller tables, RPN 0 bend range, voice scan, results.
// ---------------------------------------------------------------------------
module mcr_back #(
  parameter int VOICES = mcr_pkg::VOICES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       pop_valid,
  output logic                       pop,
  input  mcr_pkg::item_t             pop_item,
  input  logic                       cfg_we,
  input  logic [mcr_pkg::ACT_W-1:0]  cfg_wdata,
  output logic                       busy,
  mcr_out_if.source                  out_ch
);
  import mcr_pkg::*;

  localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  state_t state_r, state_nxt;

  logic [CV_W-1:0] cmem [2**CA_W];
  logic [CV_W-1:0] emem [2**EA_W];
  logic [BR_W-1:0] bmem [2**SC_W];
  logic            dmem [2**SC_W];

  logic [CV_W-1:0] cmem_rd_r, emem_rd_r;
  logic [BR_W-1:0] bmem_rd_r;
  logic            dmem_rd_r;

  logic [8:0]      bind_r [VOICES];
  logic [BR_W-1:0] vbr_r  [VOICES];

  item_t           it_r;
  logic            op_r;
  logic [CA_W-1:0] clr_r;
  logic [ACT_W-1:0] act_r, idx_r;
  logic [CV_W-1:0] lsb_r, readv_r;
  logic [BR_W-1:0] bend_r;
  logic            dirty_r, hit_r;
  logic            out_valid_r;
  res_t            out_r;

  logic [CTRL_W-1:0] cur_c, rd_c;
  logic [CV_W-1:0]   cur_v;
  logic [SC_W-1:0]   sc;
  logic [ACT_W-1:0]  n_scan;
  logic [VW-1:0]     vi;
  logic [8:0]        b;
  logic              match, can_load, load, ok, rpn_cc;
  logic [BR_W-1:0]   r_new;
  res_t              res;

  assign busy     = state_r == S_CLEAR;
  assign cur_c    = op_r ? it_r.c1 : it_r.c0;
  assign cur_v    = op_r ? it_r.v1 : it_r.v0;
  assign sc       = {it_r.set_idx, it_r.ch};
  assign n_scan   = (act_r > ACT_W'(VOICES)) ? ACT_W'(VOICES) : act_r;
  assign vi       = idx_r[VW-1:0];
  assign b        = bind_r[vi];
  assign match    = b[8] && (b[7] == it_r.fx) && (b[3:0] == it_r.ch) &&
                    (it_r.fx || (b[6:4] == it_r.set_idx));
  assign can_load = !out_valid_r || out_ch.ready;
  assign rpn_cc   = !it_r.fx && (cur_c == CC_DATA_MSB || cur_c == CC_DEC || cur_c == CC_INC);
  assign ok       = (it_r.status == ST_OK) && (it_r.kind != K_BIND) && !it_r.fx;

  always_comb begin
    r_new = bend_r;
    if (cur_c == CC_DATA_MSB) r_new = (cur_v > 7'(MAX_BEND)) ? MAX_BEND : cur_v[BR_W-1:0];
    else if (cur_c == CC_DEC) begin
      if (bend_r != '0) r_new = bend_r - 1'b1;
    end else if (bend_r < MAX_BEND) r_new = bend_r + 1'b1;
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load      = 1'b0;
    rd_c      = it_r.c0;
    res       = '0;
    unique case (state_r)
      S_CLEAR: if (clr_r == '1) state_nxt = S_IDLE;
      S_IDLE: begin
        if (pop_valid) begin
          pop       = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: state_nxt = S_LATCH;
      S_LATCH: begin
        if (it_r.kind == K_WRITE && it_r.status == ST_OK) state_nxt = S_OP;
        else state_nxt = S_FINAL;
      end
      S_OP:    state_nxt = rpn_cc ? S_RPN_L : S_WRITE;
      S_RPN_L: begin
        rd_c      = CC_RPN_LSB;
        state_nxt = S_RPN_M;
      end
      S_RPN_M: begin
        rd_c      = CC_RPN_MSB;
        state_nxt = S_RPN_EVAL;
      end
      S_RPN_EVAL: state_nxt = S_WRITE;
      S_WRITE: state_nxt = (it_r.two_ops && !op_r) ? S_OP : S_SCAN;
      S_SCAN: begin
        res.voice_index    = idx_r[SLOT_W-1:0];
        res.bend_range_set = hit_r;
        res.bend_range     = hit_r ? bend_r : vbr_r[vi];
        res.dirty_mark     = !it_r.fx;
        if (idx_r >= n_scan) state_nxt = S_FINAL;
        else if (match) load = can_load;
      end
      S_FINAL: begin
        res.kind       = 1'b1;
        res.last       = 1'b1;
        res.status     = it_r.status;
        res.bend_range = ok ? bend_r : '0;
        res.dirty_mark = ok && ((it_r.kind == K_WRITE) || dirty_r);
        res.read_value = (it_r.kind == K_READ && it_r.status == ST_OK) ? readv_r : '0;
        load           = can_load;
        if (can_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    cmem_rd_r <= cmem[{sc, rd_c}];
    emem_rd_r <= emem[{it_r.ch, it_r.c0}];
    bmem_rd_r <= bmem[sc];
    dmem_rd_r <= dmem[sc];
    if (state_r == S_CLEAR) begin
      cmem[clr_r]            <= '0;
      emem[clr_r[EA_W-1:0]]  <= '0;
      bmem[clr_r[SC_W-1:0]]  <= '0;
      dmem[clr_r[SC_W-1:0]]  <= 1'b0;
    end else if (state_r == S_WRITE) begin
      if (it_r.fx) emem[{it_r.ch, cur_c}] <= cur_v;
      else begin
        cmem[{sc, cur_c}] <= cur_v;
        dmem[sc]          <= 1'b1;
      end
    end else if (state_r == S_RPN_EVAL && lsb_r == '0 && cmem_rd_r == '0) begin
      bmem[sc] <= r_new;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) it_r <= pop_item;
    if (load) out_r <= res;
    if (state_r == S_LATCH) begin
      bend_r  <= bmem_rd_r;
      dirty_r <= dmem_rd_r;
      readv_r <= it_r.fx ? emem_rd_r : cmem_rd_r;
    end
    if (state_r == S_RPN_M) lsb_r <= cmem_rd_r;
    if (state_r == S_RPN_EVAL && lsb_r == '0 && cmem_rd_r == '0) bend_r <= r_new;
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      act_r       <= ACTIVE_RST;
      out_valid_r <= 1'b0;
      op_r        <= 1'b0;
      hit_r       <= 1'b0;
      idx_r       <= '0;
      for (int i = 0; i < VOICES; i++) begin
        bind_r[i] <= '0;
        vbr_r[i]  <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) act_r <= cfg_wdata;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (pop) begin
        op_r  <= 1'b0;
        hit_r <= 1'b0;
        idx_r <= '0;
      end
      if (state_r == S_LATCH && it_r.kind == K_BIND && it_r.slot_ok) begin
        bind_r[VW'(7'(it_r.slot))] <= it_r.bind_on ? {1'b1, it_r.fx, sc} : 9'd0;
      end
      if (state_r == S_RPN_EVAL && lsb_r == '0 && cmem_rd_r == '0) hit_r <= 1'b1;
      if (state_r == S_WRITE && it_r.two_ops && !op_r) op_r <= 1'b1;
      if (state_r == S_SCAN && idx_r < n_scan && (!match || can_load)) begin
        idx_r <= idx_r + 1'b1;
        if (match && hit_r) vbr_r[vi] <= bend_r;
      end
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.result_kind    = out_r.kind;
  assign out_ch.voice_index    = out_r.voice_index;
  assign out_ch.bend_range_set = out_r.bend_range_set;
  assign out_ch.bend_range     = out_r.bend_range;
  assign out_ch.read_value     = out_r.read_value;
  assign out_ch.dirty_mark     = out_r.dirty_mark;
  assign out_ch.status         = out_r.status;
  assign out_ch.last           = out_r.last;

endmodule

// ===== sv/midi_controller_rpn_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// midi_controller_rpn_store
// MIDI controller store with RPN 0 pitch-bend range and voice notices.
// ---------------------------------------------------------------------------
//  channel   dir   handshake      carries
//  in_ch     in    valid/ready    command item
//  out_ch    out   valid/ready    voice notices, then one final status item
//  cfg_*     in    write enable   active_voices
//
//  An item passes take, fetch and latch steps and a final status item; each
//  controller write adds an op and a write step (plus RPN LSB, MSB and
//  evaluate steps when the RPN is looked up), and a write item then scans
//  the active voice slots one slot a cycle. After reset a clearing pass over
//  the tables runs before the first item is taken. A stalled output holds the
//  scan; a two-item queue keeps input taken meanwhile.
// ---------------------------------------------------------------------------
module midi_controller_rpn_store #(
  parameter int VOICES      = mcr_pkg::VOICES_DEF,
  parameter int SETS        = mcr_pkg::SETS_DEF,
  parameter int CONTROLLERS = mcr_pkg::CONTROLLERS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  mcr_in_if.sink                    in_ch,
  mcr_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [mcr_pkg::ACT_W-1:0] cfg_wdata
);
  import mcr_pkg::*;

  item_t push_item, pop_item;
  logic  push_valid, push_ready, pop_valid, pop, busy;

  mcr_front #(.VOICES(VOICES), .SETS(SETS), .CONTROLLERS(CONTROLLERS)) u_front (
    .in_ch      (in_ch),
    .busy       (busy),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  mcr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  mcr_back #(.VOICES(VOICES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .out_ch    (out_ch)
  );

endmodule

// ===== tb/midi_controller_rpn_store_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// midi_controller_rpn_store_tb
// Self-checking bench for the MIDI controller / RPN 0 store. Command items go
// in through a queue-fed driver; a predictor keeps its own tables and voice
// bindings and queues the notices and status item that each accepted item
// should produce. A monitor compares every result item field by field.
// ---------------------------------------------------------------------------
module midi_controller_rpn_store_tb;
  import mcr_pkg::*;

  localparam int NV = 32;
  localparam int NS = 8;
  localparam int NC = 134;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  ctrl;
    logic [3:0]  ch;
    logic        absent;
    logic [2:0]  set_idx;
    logic        fx;
    logic [15:0] val;
    logic [4:0]  slot;
    logic        bind_on;
  } midi_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [ACT_W-1:0] cfg_wdata = '0;

  mcr_in_if  in_ch ();
  mcr_out_if out_ch ();

  midi_controller_rpn_store dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  logic [6:0]  cc_tab [NS][16][NC];
  logic [6:0]  fx_tab [16][NC];
  logic [4:0]  bend_tab [NS][16];
  logic        dirty_tab [NS][16];
  logic [8:0]  binding [NV];
  logic [4:0]  voice_bend [NV];
  int          scan_n;

  midi_cmd_t pending_cmds [$];
  res_t      expected_results [$];
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 1'b0;
  int        drv_gap = 0;
  int        mon_gap = 0;

  function automatic bit voice_hit(int v, logic fx, logic [2:0] s, logic [3:0] c);
    logic [8:0] b;
    b = binding[v];
    if (!b[8] || b[7] != fx || b[3:0] != c) return 1'b0;
    return fx ? 1'b1 : (b[6:4] == s);
  endfunction

  function automatic void store_cc(int cc, logic [3:0] c, logic [2:0] s, logic fx,
                                   logic [6:0] v, ref bit bend_hit);
    int r;
    if (fx) begin
      fx_tab[c][cc] = v;
      return;
    end
    if (cc == CC_DATA_MSB || cc == CC_DEC || cc == CC_INC) begin
      if (cc_tab[s][c][CC_RPN_LSB] == 0 && cc_tab[s][c][CC_RPN_MSB] == 0) begin
        r = bend_tab[s][c];
        if (cc == CC_DATA_MSB) r = (v > MAX_BEND) ? MAX_BEND : v;
        else if (cc == CC_DEC) begin
          if (r != 0) r--;
        end else if (r < MAX_BEND) r++;
        bend_tab[s][c] = 5'(r);
        for (int i = 0; i < scan_n; i++)
          if (voice_hit(i, 1'b0, s, c)) voice_bend[i] = 5'(r);
        bend_hit = 1'b1;
      end
    end
    cc_tab[s][c][cc] = v;
    dirty_tab[s][c] = 1'b1;
  endfunction

  function automatic void predict_item(midi_cmd_t m);
    logic [1:0] st;
    logic [6:0] rv, hi, lo;
    logic [4:0] br;
    logic dm;
    bit bend_hit, wrote;
    int cc;
    res_t r;
    st = ST_OK; rv = '0; br = '0; dm = 1'b0; bend_hit = 1'b0; wrote = 1'b0;
    cc = m.ctrl;
    hi = m.val[13:7];
    lo = m.val[6:0];
    if (m.cmd == CMD_BIND) begin
      binding[m.slot] = m.bind_on ? {1'b1, m.fx, m.set_idx, m.ch} : 9'd0;
    end else if (m.absent) begin
      st = ST_ABSENT;
    end else if (cc >= NC || (!m.fx && m.set_idx >= NS)) begin
      st = ST_INVALID;
    end else if (m.cmd == CMD_READ) begin
      rv = m.fx ? fx_tab[m.ch][cc] : cc_tab[m.set_idx][m.ch][cc];
    end else begin
      if (m.cmd == CMD_WR7) store_cc(cc, m.ch, m.set_idx, m.fx, lo, bend_hit);
      else if (cc < 64) begin
        store_cc(cc & 31, m.ch, m.set_idx, m.fx, hi, bend_hit);
        store_cc((cc & 31) + 32, m.ch, m.set_idx, m.fx, lo, bend_hit);
      end else if (cc == 128 || cc == 129 || cc == 132 || cc == 133) begin
        store_cc(cc & 254, m.ch, m.set_idx, m.fx, hi, bend_hit);
        store_cc((cc & 254) + 1, m.ch, m.set_idx, m.fx, lo, bend_hit);
      end else store_cc(cc, m.ch, m.set_idx, m.fx, hi, bend_hit);
      wrote = 1'b1;
    end
    if (st == ST_OK && m.cmd != CMD_BIND && !m.fx) begin
      br = bend_tab[m.set_idx][m.ch];
      dm = dirty_tab[m.set_idx][m.ch];
    end
    if (wrote)
      for (int i = 0; i < scan_n; i++)
        if (voice_hit(i, m.fx, m.set_idx, m.ch)) begin
          r = '0;
          r.voice_index = 5'(i);
          r.bend_range_set = bend_hit;
          r.bend_range = voice_bend[i];
          r.dirty_mark = dm;
          expected_results.push_back(r);
        end
    r = '0;
    r.kind = 1'b1;
    r.bend_range = br;
    r.read_value = rv;
    r.dirty_mark = dm;
    r.status = st;
    r.last = 1'b1;
    expected_results.push_back(r);
  endfunction

  function automatic midi_cmd_t mk(cmd_t c, int cc, int ch, int s, int v);
    midi_cmd_t m;
    m = '0;
    m.cmd = c; m.ctrl = 8'(cc); m.ch = 4'(ch); m.set_idx = 3'(s); m.val = 16'(v);
    return m;
  endfunction

  function automatic midi_cmd_t bind_cmd(int slot, bit on, bit fx, int s, int ch);
    midi_cmd_t m;
    m = mk(CMD_BIND, $urandom_range(255), ch, s, $urandom);
    m.slot = 5'(slot); m.bind_on = on; m.fx = fx; m.absent = 1'($urandom_range(1));
    return m;
  endfunction

  function automatic midi_cmd_t random_cmd();
    midi_cmd_t m;
    int p;
    p = $urandom_range(99);
    m.cmd = cmd_t'($urandom_range(3));
    m.ch = 4'($urandom_range(3));
    m.set_idx = 3'($urandom_range(1));
    m.fx = ($urandom_range(9) == 0);
    m.absent = ($urandom_range(19) == 0);
    m.val = 16'($urandom);
    m.slot = 5'($urandom);
    m.bind_on = ($urandom_range(3) != 0);
    if (p < 35) m.ctrl = 8'(CC_DATA_MSB + $urandom_range(1) * (CC_DEC - CC_DATA_MSB)
                            + (($urandom_range(2) == 2) ? 1 : 0));
    else if (p < 45) m.ctrl = 8'(CC_RPN_LSB + $urandom_range(1));
    else if (p < 55) m.ctrl = 8'(128 + $urandom_range(5));
    else if (p < 65) m.ctrl = 8'($urandom_range(255));
    else m.ctrl = 8'($urandom_range(133));
    if (m.ctrl == CC_RPN_LSB || m.ctrl == CC_RPN_MSB)
      m.val = ($urandom_range(2) == 0) ? 16'($urandom) : 16'd0;
    if ($urandom_range(15) == 0) begin
      m.ch = 4'($urandom); m.set_idx = 3'($urandom);
    end
    return m;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (drv_gap > 0) begin
      drv_gap <= drv_gap - 1;
      in_ch.valid <= 1'b0;
    end else if (!calm && !(in_ch.valid && in_ch.ready) && $urandom_range(5) == 0) begin
      drv_gap <= $urandom_range(5);
      in_ch.valid <= 1'b0;
    end else if (pending_cmds.size() > 0) begin
      midi_cmd_t m;
      m = pending_cmds.pop_front();
      predict_item(m);
      in_ch.valid <= 1'b1;
      in_ch.command <= m.cmd;
      in_ch.controller <= m.ctrl;
      in_ch.channel <= m.ch;
      in_ch.channel_absent <= m.absent;
      in_ch.set_index <= m.set_idx;
      in_ch.fx_set <= m.fx;
      in_ch.value <= m.val;
      in_ch.voice_slot <= m.slot;
      in_ch.bind_valid <= m.bind_on;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: kind %0d voice %0d",
                 out_ch.result_kind, out_ch.voice_index);
          errors++;
        end else begin
          res_t e;
          e = expected_results.pop_front();
          if (out_ch.result_kind !== e.kind) begin
            $error("result_kind exp %0d got %0d", e.kind, out_ch.result_kind); errors++;
          end
          if (out_ch.voice_index !== e.voice_index) begin
            $error("voice_index exp %0d got %0d", e.voice_index, out_ch.voice_index); errors++;
          end
          if (out_ch.bend_range_set !== e.bend_range_set) begin
            $error("bend_range_set exp %0d got %0d", e.bend_range_set,
                   out_ch.bend_range_set); errors++;
          end
          if (out_ch.bend_range !== e.bend_range) begin
            $error("bend_range exp %0d got %0d", e.bend_range, out_ch.bend_range); errors++;
          end
          if (out_ch.read_value !== e.read_value) begin
            $error("read_value exp %0d got %0d", e.read_value, out_ch.read_value); errors++;
          end
          if (out_ch.dirty_mark !== e.dirty_mark) begin
            $error("dirty_mark exp %0d got %0d", e.dirty_mark, out_ch.dirty_mark); errors++;
          end
          if (out_ch.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_ch.status); errors++;
          end
          if (out_ch.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, out_ch.last); errors++;
          end
        end
      end
      if (mon_gap > 0) begin
        mon_gap <= mon_gap - 1;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(4) == 0) begin
        mon_gap <= $urandom_range(5);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_voices(int n);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= ACT_W'(n);
    @(posedge clk);
    cfg_we <= 1'b0;
    scan_n = (n > NV) ? NV : n;
  endtask

  initial begin
    midi_cmd_t m;
    int settings [4];
    settings = '{32, 0, 63, 7};
    in_ch.valid = 1'b0; in_ch.command = CMD_WR7; in_ch.controller = '0;
    in_ch.channel = '0; in_ch.channel_absent = 1'b0; in_ch.set_index = '0;
    in_ch.fx_set = 1'b0; in_ch.value = '0; in_ch.voice_slot = '0; in_ch.bind_valid = 1'b0;
    out_ch.ready = 1'b0;
    foreach (cc_tab[s, c, k]) cc_tab[s][c][k] = '0;
    foreach (fx_tab[c, k]) fx_tab[c][k] = '0;
    foreach (bend_tab[s, c]) begin
      bend_tab[s][c] = '0; dirty_tab[s][c] = 1'b0;
    end
    foreach (binding[v]) begin
      binding[v] = '0; voice_bend[v] = '0;
    end
    scan_n = NV;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    pending_cmds.push_back(bind_cmd(0, 1, 0, 0, 0));
    pending_cmds.push_back(bind_cmd(31, 1, 0, 0, 0));
    pending_cmds.push_back(bind_cmd(5, 1, 1, 7, 15));
    pending_cmds.push_back(mk(CMD_WR7, CC_DATA_MSB, 0, 0, 16'hFFFF));
    pending_cmds.push_back(mk(CMD_WR7, CC_INC, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_WR7, CC_DATA_MSB, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_WR7, CC_DEC, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_WR7, CC_DATA_MSB, 0, 0, 10));
    pending_cmds.push_back(mk(CMD_WR14, 63, 0, 0, 16'hFFFF));
    pending_cmds.push_back(mk(CMD_WR14, 129, 0, 0, 16'h2A55));
    pending_cmds.push_back(mk(CMD_WR14, 133, 0, 7, 16'h1234));
    pending_cmds.push_back(mk(CMD_WR14, 100, 0, 0, 16'h0080));
    pending_cmds.push_back(mk(CMD_WR7, CC_INC, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_READ, 133, 0, 7, 0));
    pending_cmds.push_back(mk(CMD_READ, 0, 0, 0, 0));
    pending_cmds.push_back(mk(CMD_WR7, 134, 0, 0, 1));
    pending_cmds.push_back(mk(CMD_WR7, 255, 0, 0, 1));
    m = mk(CMD_WR7, 7, 15, 7, 16'h7F); m.fx = 1'b1;
    pending_cmds.push_back(m);
    m = mk(CMD_READ, 7, 15, 0, 0); m.fx = 1'b1;
    pending_cmds.push_back(m);
    m = mk(CMD_WR7, 7, 3, 0, 5); m.absent = 1'b1;
    pending_cmds.push_back(m);
    pending_cmds.push_back(bind_cmd(31, 0, 0, 0, 0));
    drain();

    foreach (settings[p]) begin
      set_voices(settings[p]);
      if (p == 3) calm = 1'b1;
      for (int i = 0; i < 108; i++) begin
        if ($urandom_range(4) == 0)
          pending_cmds.push_back(bind_cmd($urandom, $urandom_range(3) != 0,
                                          $urandom_range(7) == 0, $urandom_range(1),
                                          $urandom_range(3)));
        else pending_cmds.push_back(random_cmd());
      end
      drain();
    end

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

// ===== files.f =====
sv/mcr_pkg.sv
sv/mcr_if.sv
sv/mcr_front.sv
sv/mcr_fifo.sv
sv/mcr_back.sv
sv/midi_controller_rpn_store.sv
tb/midi_controller_rpn_store_tb.sv
